// ===== rtl/scmttkrp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scmttkrp_pkg
// Shared types, sizes and codes of the sparse COO MTTKRP accumulator.
// ----------------------------------------------------------------------------
package scmttkrp_pkg;

  localparam int unsigned MaxModes = 4;
  localparam int unsigned MaxDim   = 1024;
  localparam int unsigned MaxRank  = 16;

  localparam int unsigned ModeW  = $clog2(MaxModes);
  localparam int unsigned DimW   = $clog2(MaxDim);
  localparam int unsigned RankW  = $clog2(MaxRank);
  localparam int unsigned FacAw  = ModeW + DimW + RankW;
  localparam int unsigned OutAw  = DimW + RankW;
  localparam int unsigned DataW  = 32;
  localparam int unsigned ModeCntW = $clog2(MaxModes + 1);
  localparam int unsigned RankCntW = $clog2(MaxRank + 1);

  // register indexes of the configuration port
  localparam logic [1:0] RegNumModes   = 2'd0;
  localparam logic [1:0] RegTargetMode = 2'd1;
  localparam logic [1:0] RegRankInUse  = 2'd2;

  // item actions
  localparam logic [1:0] ActClear   = 2'd0;
  localparam logic [1:0] ActLoad    = 2'd1;
  localparam logic [1:0] ActNonzero = 2'd2;
  localparam logic [1:0] ActRead    = 2'd3;

  typedef struct packed {
    logic             we;
    logic [FacAw-1:0] waddr;
    logic [DataW-1:0] wdata;
    logic [FacAw-1:0] raddr;
  } fac_req_t;

  typedef struct packed {
    logic             we;
    logic [OutAw-1:0] waddr;
    logic [DataW-1:0] wdata;
    logic [OutAw-1:0] raddr;
  } out_req_t;

  function automatic logic signed [DataW-1:0] sat_add(input logic signed [DataW-1:0] a,
                                                      input logic signed [DataW-1:0] b);
    logic signed [DataW:0] s;
    s = {a[DataW-1], a} + {b[DataW-1], b};
    if (s[DataW] != s[DataW-1]) begin
      sat_add = s[DataW] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end else begin
      sat_add = s[DataW-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/scmttkrp_factor_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scmttkrp_factor_mem
// Factor matrix storage, one write and one registered read port.
// ----------------------------------------------------------------------------
module scmttkrp_factor_mem
  import scmttkrp_pkg::*;
(
  input  wire logic             clk_i,
  input  fac_req_t              req_i,
  output logic      [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [2**FacAw];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem[req_i.raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/scmttkrp_out_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scmttkrp_out_mem
// Output matrix storage, one write and one registered read port.
// ----------------------------------------------------------------------------
module scmttkrp_out_mem
  import scmttkrp_pkg::*;
(
  input  wire logic             clk_i,
  input  out_req_t              req_i,
  output logic      [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [2**OutAw];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem[req_i.raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/scmttkrp_qmul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scmttkrp_qmul
// Q16.16 multiply: registered 64-bit product, then floor shift and saturate.
// ----------------------------------------------------------------------------
module scmttkrp_qmul
  import scmttkrp_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    start_i,
  input  wire logic signed [DataW-1:0] a_i,
  input  wire logic signed [DataW-1:0] b_i,
  output logic signed      [DataW-1:0] p_o
);

  logic signed [2*DataW-1:0] prod_q;
  logic signed [2*DataW-1:0] shifted;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= a_i * b_i;
    end
  end

  always_comb begin
    shifted = prod_q >>> 16;
    // fits when the result sign bit and all bits above it agree
    if ((&shifted[2*DataW-1:DataW-1]) || !(|shifted[2*DataW-1:DataW-1])) begin
      p_o = shifted[DataW-1:0];
    end else if (shifted[2*DataW-1]) begin
      p_o = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      p_o = {1'b0, {(DataW-1){1'b1}}};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sparse_coo_mttkrp_accumulator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_coo_mttkrp_accumulator
// COO sparse tensor MTTKRP: factor memory, output memory, Q16.16 datapath.
// ----------------------------------------------------------------------------
// Load writes one factor entry. Read passes the output memory read register and
//   the result register to the output register. Clear zeroes all 16384 entries.
// Nonzero: R rank columns over M modes, then a done item if it is the last one;
//   no columns when the target mode is unused; each factor read, multiply and
//   saturate shares one multiplier; each column ends in an output memory read-modify-write.
// One item is processed at a time; a result waits in an output register.
// After reset the output memory is swept to zero before the
//   first item is taken; configuration writes are taken throughout.
module sparse_coo_mttkrp_accumulator
  import scmttkrp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [4:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // factor_mode[1:0], row_index[11:2], column[15:12], value[47:16],
  // idx_0[57:48], idx_1[67:58], idx_2[77:68], idx_3[87:78]
  input  wire logic [87:0] s_axis_tdata,
  // action[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // read_value[31:0]
  output logic [31:0]      m_axis_tdata,
  // done_res[0]
  output logic [0:0]       m_axis_tuser
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MODE, S_FMUL, S_FSAT, S_OREAD, S_OWRITE, S_RREAD, S_EMIT
  } state_e;

  state_e state_q;

  logic [2:0]           num_modes_q;
  logic [ModeW-1:0]     target_mode_q;
  logic [RankCntW-1:0]  rank_in_use_q;

  logic [OutAw-1:0]     clr_cnt_q;
  logic [ModeCntW-1:0]  modes_q;
  logic [RankCntW-1:0]  rank_q;
  logic [ModeCntW-1:0]  m_q;
  logic [RankCntW-1:0]  r_q;
  logic [DimW-1:0]      idx_q [MaxModes];
  logic signed [DataW-1:0] value_q;
  logic signed [DataW-1:0] p_q;
  logic                 last_q;
  logic [DataW-1:0]     res_val_q;
  logic                 res_done_q;
  logic                 out_valid_q;
  logic [DataW-1:0]     out_data_q;
  logic                 out_done_q;

  fac_req_t             fac_req;
  out_req_t             out_req;
  logic [DataW-1:0]     fac_rdata;
  logic [DataW-1:0]     out_rdata;
  logic signed [DataW-1:0] qmul_p;

  logic                 accept;
  logic                 out_load;
  logic [1:0]           in_action;
  logic [ModeW-1:0]     in_fmode;
  logic [DimW-1:0]      in_row;
  logic [RankW-1:0]     in_col;
  logic [ModeCntW-1:0]  modes_eff;
  logic [RankCntW-1:0]  rank_eff;

  assign in_action = s_axis_tuser;
  assign in_fmode  = s_axis_tdata[1:0];
  assign in_row    = s_axis_tdata[11:2];
  assign in_col    = s_axis_tdata[15:12];

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == S_EMIT) && (!out_valid_q || m_axis_tready);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_done_q;

  // clamp the mode count into 2..MaxModes and the rank to MaxRank
  always_comb begin
    if (num_modes_q < 3'd2) begin
      modes_eff = ModeCntW'(2);
    end else if ({1'b0, num_modes_q} > 4'(MaxModes)) begin
      modes_eff = ModeCntW'(MaxModes);
    end else begin
      modes_eff = ModeCntW'(num_modes_q);
    end
    if (rank_in_use_q > RankCntW'(MaxRank)) begin
      rank_eff = RankCntW'(MaxRank);
    end else begin
      rank_eff = rank_in_use_q;
    end
  end

  always_comb begin
    fac_req.we    = accept && (in_action == ActLoad);
    fac_req.waddr = {in_fmode, in_row, in_col};
    fac_req.wdata = s_axis_tdata[47:16];
    fac_req.raddr = {m_q[ModeW-1:0], idx_q[m_q[ModeW-1:0]], r_q[RankW-1:0]};

    out_req.we    = 1'b0;
    out_req.waddr = clr_cnt_q;
    out_req.wdata = '0;
    out_req.raddr = {idx_q[target_mode_q], r_q[RankW-1:0]};
    if (state_q == S_CLEAR) begin
      out_req.we = 1'b1;
    end else if (state_q == S_OWRITE) begin
      out_req.we    = 1'b1;
      out_req.waddr = {idx_q[target_mode_q], r_q[RankW-1:0]};
      out_req.wdata = sat_add(out_rdata, p_q);
    end
    if (state_q == S_IDLE) begin
      out_req.raddr = {in_row, in_col};
    end
  end

  scmttkrp_factor_mem u_fac (
    .clk_i   (clk_i),
    .req_i   (fac_req),
    .rdata_o (fac_rdata)
  );

  scmttkrp_out_mem u_out (
    .clk_i   (clk_i),
    .req_i   (out_req),
    .rdata_o (out_rdata)
  );

  scmttkrp_qmul u_qmul (
    .clk_i   (clk_i),
    .start_i (state_q == S_FMUL),
    .a_i     (p_q),
    .b_i     (fac_rdata),
    .p_o     (qmul_p)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_modes_q   <= 3'd3;
      target_mode_q <= '0;
      rank_in_use_q <= RankCntW'(MaxRank);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegNumModes:   num_modes_q   <= cfg_data_i[2:0];
        RegTargetMode: target_mode_q <= cfg_data_i[ModeW-1:0];
        RegRankInUse:  rank_in_use_q <= cfg_data_i[RankCntW-1:0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      m_q         <= '0;
      r_q         <= '0;
      modes_q     <= '0;
      rank_q      <= '0;
      last_q      <= 1'b0;
      res_done_q  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_data_q  <= res_val_q;
        out_done_q  <= res_done_q;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (&clr_cnt_q) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            value_q  <= s_axis_tdata[47:16];
            p_q      <= s_axis_tdata[47:16];
            idx_q[0] <= s_axis_tdata[57:48];
            idx_q[1] <= s_axis_tdata[67:58];
            idx_q[2] <= s_axis_tdata[77:68];
            idx_q[3] <= s_axis_tdata[87:78];
            last_q   <= s_axis_tlast;
            modes_q  <= modes_eff;
            rank_q   <= rank_eff;
            m_q      <= '0;
            r_q      <= '0;
            case (in_action)
              ActClear: begin
                clr_cnt_q <= '0;
                state_q   <= S_CLEAR;
              end
              ActNonzero: begin
                res_val_q  <= '0;
                res_done_q <= 1'b1;
                if ({1'b0, target_mode_q} >= modes_eff || rank_eff == '0) begin
                  // nothing to accumulate
                  state_q <= s_axis_tlast ? S_EMIT : S_IDLE;
                end else begin
                  state_q <= S_MODE;
                end
              end
              ActRead: begin
                state_q <= S_RREAD;
              end
              default: ;
            endcase
          end
        end
        S_MODE: begin
          if (m_q >= modes_q) begin
            state_q <= S_OREAD;
          end else if (m_q[ModeW-1:0] == target_mode_q) begin
            m_q <= m_q + 1'b1;
          end else begin
            state_q <= S_FMUL;
          end
        end
        S_FMUL: begin
          state_q <= S_FSAT;
        end
        S_FSAT: begin
          p_q     <= qmul_p;
          m_q     <= m_q + 1'b1;
          state_q <= S_MODE;
        end
        S_OREAD: begin
          state_q <= S_OWRITE;
        end
        S_OWRITE: begin
          r_q <= r_q + 1'b1;
          m_q <= '0;
          p_q <= value_q;
          if (r_q + 1'b1 == rank_q) begin
            state_q <= last_q ? S_EMIT : S_IDLE;
          end else begin
            state_q <= S_MODE;
          end
        end
        S_RREAD: begin
          res_val_q  <= out_rdata;
          res_done_q <= 1'b0;
          state_q    <= S_EMIT;
        end
        S_EMIT: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_load_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fac_req.we |-> (state_q == S_IDLE))
    else $error("factor write outside idle");

  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !s_axis_tready)
    else $error("input taken during clear sweep");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !$past(m_axis_tvalid)) |-> ($past(state_q) == S_EMIT))
    else $error("result raised outside emit");

  a_mode_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FMUL) |-> (m_q < modes_q && m_q[ModeW-1:0] != target_mode_q))
    else $error("factor read of an unused mode");

endmodule
`default_nettype wire
